/* sv/gzip_header_checker_defines.svh */
// Assertion macros for the gzip header checker.
`ifndef GZIP_HEADER_CHECKER_DEFINES_SVH
`define GZIP_HEADER_CHECKER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define GHC_ASSERT_SAME(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define GHC_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* sv/ghc_pkg.sv */
// Constants and result codes of the gzip header checker.
package ghc_pkg;

  localparam logic [7:0]  MAGIC_A    = 8'h1f;
  localparam logic [7:0]  MAGIC_B    = 8'h8b;
  localparam logic [7:0]  METHOD_DEF = 8'h08;
  localparam logic [7:0]  FLG_RSVD   = 8'hE0;
  localparam logic [4:0]  FLG_HCRC   = 5'h02;
  localparam logic [4:0]  FLG_EXTRA  = 5'h04;
  localparam logic [4:0]  FLG_NAME   = 5'h08;
  localparam logic [4:0]  FLG_CMNT   = 5'h10;
  localparam int unsigned LEN_W      = 20;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [15:0] FIXED_LEN  = 16'd6;
  localparam logic [15:0] HCRC_LEN   = 16'd2;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_FIRST   = 2'd1,
    ST_PAYLOAD = 2'd2,
    ST_ERROR   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_METHOD = 3'd2,
    ERR_RSVD   = 3'd3,
    ERR_TRUNC  = 3'd4
  } cause_e;

endpackage

/* sv/gzip_header_checker.sv */
// Gzip member header checker: one byte per cycle while not stalled, input and
// result registers. Takes one byte in every cycle that the input is not stalled
// and returns one result word for each byte. Each byte passes through the
// input register and then the result register. The input stalls only while
// a result word waits under output stall. The parse state (phase, skip count,
// flags, length, error) is updated as a byte moves from the input register to
// the result register, so back-to-back bytes each see the state left by the
// one before. A start request on a byte clears the state before that byte is
// checked. Errors stick until the next start request.
`include "gzip_header_checker_defines.svh"

module gzip_header_checker
  import ghc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_req_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [2:0]       error_cause_o,
  output logic [4:0]       header_flags_o,
  output logic [LEN_W-1:0] header_length_o
);

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLO     = 4'd5,
    PH_XHI     = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_CMNT    = 4'd9,
    PH_HCRC    = 4'd10,
    PH_FIRST   = 4'd11,
    PH_PAYLOAD = 4'd12,
    PH_ERROR   = 4'd13
  } phase_e;

  function automatic phase_e next_section(phase_e from, logic [4:0] flags);
    phase_e res;
    if (from <= PH_XLO && (flags & FLG_EXTRA) != '0) begin
      res = PH_XLO;
    end else if (from <= PH_NAME && (flags & FLG_NAME) != '0) begin
      res = PH_NAME;
    end else if (from <= PH_CMNT && (flags & FLG_CMNT) != '0) begin
      res = PH_CMNT;
    end else if (from <= PH_HCRC && (flags & FLG_HCRC) != '0) begin
      res = PH_HCRC;
    end else begin
      res = PH_FIRST;
    end
    return res;
  endfunction

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_start_q;
  logic             in_last_q;
  logic             adv;

  phase_e           phase_q, phase_d, ph;
  logic [4:0]       flags_q, flags_d, fl;
  logic [15:0]      skip_q, skip_d, sk, sk_dec, sk_ext;
  logic [LEN_W-1:0] hbytes_q, hbytes_d, hb;
  cause_e           err_q, err_d, ec, err_new;
  status_e          st;
  logic             consumed;

  logic             out_valid_q;
  status_e          status_q;
  cause_e           cause_q;
  logic [4:0]       flags_out_q;
  logic [LEN_W-1:0] len_out_q;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_req_i;
      in_last_q  <= last_byte_i;
    end
  end

  always_comb begin
    ph = phase_q;
    fl = flags_q;
    sk = skip_q;
    hb = hbytes_q;
    ec = err_q;
    if (in_start_q) begin
      ph = PH_MAGIC1;
      fl = '0;
      sk = '0;
      hb = '0;
      ec = ERR_NONE;
    end
    phase_d  = ph;
    flags_d  = fl;
    skip_d   = sk;
    hbytes_d = hb;
    err_d    = ec;
    st       = ST_HEADER;
    err_new  = ERR_NONE;
    consumed = 1'b0;
    sk_dec   = (sk != '0) ? sk - 16'd1 : sk;
    sk_ext   = {in_byte_q, sk[7:0]};
    unique case (ph)
      PH_PAYLOAD: st = ST_PAYLOAD;
      PH_FIRST: begin
        st      = ST_FIRST;
        phase_d = PH_PAYLOAD;
      end
      PH_MAGIC1: begin
        if (in_byte_q == MAGIC_A) begin
          consumed = 1'b1;
          phase_d  = PH_MAGIC2;
        end else begin
          err_new = ERR_MAGIC;
        end
      end
      PH_MAGIC2: begin
        if (in_byte_q == MAGIC_B) begin
          consumed = 1'b1;
          phase_d  = PH_METHOD;
        end else begin
          err_new = ERR_MAGIC;
        end
      end
      PH_METHOD: begin
        if (in_byte_q == METHOD_DEF) begin
          consumed = 1'b1;
          phase_d  = PH_FLAGS;
        end else begin
          err_new = ERR_METHOD;
        end
      end
      PH_FLAGS: begin
        flags_d = in_byte_q[4:0];
        if ((in_byte_q & FLG_RSVD) != '0) begin
          err_new = ERR_RSVD;
        end else begin
          consumed = 1'b1;
          skip_d   = FIXED_LEN;
          phase_d  = PH_FIXED;
        end
      end
      PH_FIXED: begin
        consumed = 1'b1;
        skip_d   = sk_dec;
        if (sk_dec == '0) phase_d = next_section(PH_XLO, fl);
      end
      PH_XLO: begin
        consumed = 1'b1;
        skip_d   = {8'd0, in_byte_q};
        phase_d  = PH_XHI;
      end
      PH_XHI: begin
        consumed = 1'b1;
        skip_d   = sk_ext;
        phase_d  = (sk_ext == '0) ? next_section(PH_NAME, fl) : PH_EXTRA;
      end
      PH_EXTRA: begin
        consumed = 1'b1;
        skip_d   = sk_dec;
        if (sk_dec == '0) phase_d = next_section(PH_NAME, fl);
      end
      PH_NAME: begin
        consumed = 1'b1;
        if (in_byte_q == 8'd0) phase_d = next_section(PH_CMNT, fl);
      end
      PH_CMNT: begin
        consumed = 1'b1;
        if (in_byte_q == 8'd0) phase_d = next_section(PH_HCRC, fl);
      end
      PH_HCRC: begin
        consumed = 1'b1;
        skip_d   = sk_dec;
        if (sk_dec == '0) phase_d = PH_FIRST;
      end
      default: st = ST_ERROR;
    endcase
    if (phase_d == PH_HCRC && ph != PH_HCRC) skip_d = HCRC_LEN;
    if (err_new != ERR_NONE) begin
      err_d   = err_new;
      phase_d = PH_ERROR;
      st      = ST_ERROR;
    end
    if (consumed) begin
      if (hb != LEN_MAX) hbytes_d = hb + LEN_W'(1);
      if (in_last_q) begin
        err_d   = ERR_TRUNC;
        phase_d = PH_ERROR;
        st      = ST_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC1;
      flags_q     <= '0;
      skip_q      <= '0;
      hbytes_q    <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
      status_q    <= ST_HEADER;
      cause_q     <= ERR_NONE;
      flags_out_q <= '0;
      len_out_q   <= '0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        phase_q     <= phase_d;
        flags_q     <= flags_d;
        skip_q      <= skip_d;
        hbytes_q    <= hbytes_d;
        err_q       <= err_d;
        status_q    <= st;
        cause_q     <= (st == ST_ERROR) ? err_d : ERR_NONE;
        flags_out_q <= flags_d;
        len_out_q   <= hbytes_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign error_cause_o   = cause_q;
  assign header_flags_o  = flags_out_q;
  assign header_length_o = len_out_q;

  `GHC_ASSERT_SAME(a_err_has_cause, phase_q == PH_ERROR, err_q != ERR_NONE,
                   "error phase without a cause")
  `GHC_ASSERT_SAME(a_hcrc_count, phase_q == PH_HCRC, skip_q != '0,
                   "header crc phase with empty count")
  `GHC_ASSERT_SAME(a_cause_only_on_error, out_valid_o && status_o != ST_ERROR,
                   error_cause_o == ERR_NONE, "cause reported without error")
  `GHC_ASSERT_NEXT(a_hold_input, in_valid_q && !adv, in_valid_q,
                   "input word dropped while stalled")

endmodule
